/* sv/qsbe_pkg.sv */
// Package for the quicksort buffer engine.
// Holds opcodes, word types, and the controller/datapath command and status types.
// No dependencies.
package qsbe_pkg;

	localparam int DEPTH_DEF      = 1024;
	localparam int DATA_WIDTH_DEF = 32;

	localparam logic [1:0] OP_LOAD  = 2'd0;
	localparam logic [1:0] OP_SORT  = 2'd1;
	localparam logic [1:0] OP_READ  = 2'd2;
	localparam logic [1:0] OP_CLEAR = 2'd3;

	// memory read address sources
	localparam logic [2:0] RA_IDX = 3'd0;
	localparam logic [2:0] RA_TOP = 3'd1;
	localparam logic [2:0] RA_LO1 = 3'd2;
	localparam logic [2:0] RA_I1  = 3'd3;
	localparam logic [2:0] RA_PL1 = 3'd4;
	localparam logic [2:0] RA_PL  = 3'd5;

	// memory write address/data pairs
	localparam logic [2:0] WR_LOAD = 3'd0;
	localparam logic [2:0] WR_SWA  = 3'd1;
	localparam logic [2:0] WR_SWB  = 3'd2;
	localparam logic [2:0] WR_FIN2 = 3'd3;
	localparam logic [2:0] WR_FIN3 = 3'd4;

	typedef struct packed {
		logic [1:0]         opcode;
		logic signed [31:0] data_value;
		logic [9:0]         read_index;
	} req_t;

	typedef struct packed {
		logic signed [31:0] out_value;
		logic [10:0]        out_count;
		logic               index_error;
		logic               overflow_seen;
	} rsp_t;

	typedef struct packed {
		logic       rd_en;
		logic [2:0] rd_sel;
		logic       wr_en;
		logic [2:0] wr_sel;
		logic       load;
		logic       clear;
		logic       read;
		logic       pop;
		logic       start_part;
		logic       take_lt;
		logic       step_i;
		logic       save_vp;
		logic       push_init;
		logic       push_a;
		logic       push_b;
		logic       done;
	} dp_cmd_t;

	typedef struct packed {
		logic lt;
		logic scan_end;
		logic stk_empty;
		logic few;
	} dp_sts_t;

endpackage

/* sv/qsbe_mem.sv */
// Value buffer memory: one write port, one read port with registered read data.
// Depends on nothing but its parameters.
module qsbe_mem #(
	parameter int DEPTH      = 1024,
	parameter int DATA_WIDTH = 32
) (
	input  logic                         clk,
	input  logic                         wr_en,
	input  logic [$clog2(DEPTH)-1:0]     wr_addr,
	input  logic [DATA_WIDTH-1:0]        wr_data,
	input  logic                         rd_en,
	input  logic [$clog2(DEPTH)-1:0]     rd_addr,
	output logic [DATA_WIDTH-1:0]        rd_data
);

	logic [DATA_WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

/* sv/qsbe_dp.sv */
// Datapath: buffer memory, count and overflow, partition registers, range stack, result word.
// Depends on qsbe_pkg and qsbe_mem.
module qsbe_dp #(
	parameter int DEPTH      = qsbe_pkg::DEPTH_DEF,
	parameter int DATA_WIDTH = qsbe_pkg::DATA_WIDTH_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  qsbe_pkg::req_t    req,
	input  qsbe_pkg::dp_cmd_t cmd,
	output qsbe_pkg::dp_sts_t sts,
	output logic              strobe,
	output qsbe_pkg::rsp_t    rsp
);

	localparam int ADDR_W = $clog2(DEPTH);
	localparam int CNT_W  = $clog2(DEPTH + 1);
	localparam int SK_D   = ADDR_W + 2;
	localparam int SP_W   = $clog2(SK_D + 1);
	localparam int SI_W   = $clog2(SK_D);
	localparam int CMPW   = CNT_W + 10;

	logic [CNT_W-1:0] count_q;
	logic             ovf_q;
	logic [CNT_W-1:0] lo_q, hi_q, i_q, place_q;
	logic [CNT_W-1:0] lo_nx, i_nx, pl_nx;
	logic [DATA_WIDTH-1:0] pivot_q, vi_q, vp_q;
	logic [2*CNT_W-1:0] stk_q [SK_D];
	logic [SP_W-1:0]  sp_q, sp_m1;
	logic [CNT_W-1:0] top_lo, top_hi;
	logic [CNT_W-1:0] left_sz, right_sz;
	logic [CNT_W-1:0] push_lo, push_hi;
	logic             push_en, push_ok, full;

	logic                  mem_we;
	logic [ADDR_W-1:0]     mem_wa, mem_ra;
	logic [DATA_WIDTH-1:0] mem_wd, rd_data;
	logic [DATA_WIDTH+31:0] in_ext, out_ext;
	logic [CMPW-1:0]       idx_ext, cnt_ext;
	logic                  read_err;

	logic        strobe_q, kind_rd_q, err_q, rsp_ovf_q;
	logic [10:0] rsp_cnt_q;

	assign lo_nx   = lo_q + CNT_W'(1);
	assign i_nx    = i_q + CNT_W'(1);
	assign pl_nx   = place_q + CNT_W'(1);
	assign sp_m1   = sp_q - SP_W'(1);
	assign top_lo  = stk_q[sp_m1[SI_W-1:0]][2*CNT_W-1:CNT_W];
	assign top_hi  = stk_q[sp_m1[SI_W-1:0]][CNT_W-1:0];
	assign full    = (count_q == CNT_W'(DEPTH));
	assign in_ext  = {{DATA_WIDTH{req.data_value[31]}}, req.data_value};
	assign out_ext = {{32{rd_data[DATA_WIDTH-1]}}, rd_data};
	assign idx_ext = {{CNT_W{1'b0}}, req.read_index};
	assign cnt_ext = {{10{1'b0}}, count_q};
	assign read_err = !(idx_ext < cnt_ext);

	assign left_sz  = place_q - lo_q;
	assign right_sz = hi_q - pl_nx;

	assign sts.lt        = $signed(rd_data) < $signed(pivot_q);
	assign sts.scan_end  = (i_nx == hi_q);
	assign sts.stk_empty = (sp_q == '0);
	assign sts.few       = (count_q < CNT_W'(2));

	always_comb begin
		mem_ra = '0;
		unique case (cmd.rd_sel)
			qsbe_pkg::RA_IDX: mem_ra = idx_ext[ADDR_W-1:0];
			qsbe_pkg::RA_TOP: mem_ra = top_lo[ADDR_W-1:0];
			qsbe_pkg::RA_LO1: mem_ra = lo_nx[ADDR_W-1:0];
			qsbe_pkg::RA_I1:  mem_ra = i_nx[ADDR_W-1:0];
			qsbe_pkg::RA_PL1: mem_ra = pl_nx[ADDR_W-1:0];
			qsbe_pkg::RA_PL:  mem_ra = place_q[ADDR_W-1:0];
			default:          mem_ra = '0;
		endcase
	end

	always_comb begin
		mem_wa = '0;
		mem_wd = '0;
		unique case (cmd.wr_sel)
			qsbe_pkg::WR_LOAD: begin
				mem_wa = count_q[ADDR_W-1:0];
				mem_wd = in_ext[DATA_WIDTH-1:0];
			end
			qsbe_pkg::WR_SWA: begin
				mem_wa = place_q[ADDR_W-1:0];
				mem_wd = vi_q;
			end
			qsbe_pkg::WR_SWB: begin
				mem_wa = i_q[ADDR_W-1:0];
				mem_wd = vp_q;
			end
			qsbe_pkg::WR_FIN2: begin
				mem_wa = lo_q[ADDR_W-1:0];
				mem_wd = rd_data;
			end
			qsbe_pkg::WR_FIN3: begin
				mem_wa = place_q[ADDR_W-1:0];
				mem_wd = pivot_q;
			end
			default: begin
				mem_wa = '0;
				mem_wd = '0;
			end
		endcase
	end

	assign mem_we = cmd.wr_en && !((cmd.wr_sel == qsbe_pkg::WR_LOAD) && full);

	qsbe_mem #(
		.DEPTH      (DEPTH),
		.DATA_WIDTH (DATA_WIDTH)
	) u_mem (
		.clk     (clk),
		.wr_en   (mem_we),
		.wr_addr (mem_wa),
		.wr_data (mem_wd),
		.rd_en   (cmd.rd_en),
		.rd_addr (mem_ra),
		.rd_data (rd_data)
	);

	// smaller side goes on the stack last so it is popped first
	always_comb begin
		push_en = 1'b0;
		push_lo = lo_q;
		push_hi = place_q;
		priority if (cmd.push_init) begin
			push_en = 1'b1;
			push_lo = '0;
			push_hi = count_q;
		end else if (cmd.push_a) begin
			push_en = 1'b1;
			if (left_sz > right_sz) begin
				push_lo = lo_q;
				push_hi = place_q;
			end else begin
				push_lo = pl_nx;
				push_hi = hi_q;
			end
		end else if (cmd.push_b) begin
			push_en = 1'b1;
			if (left_sz > right_sz) begin
				push_lo = pl_nx;
				push_hi = hi_q;
			end else begin
				push_lo = lo_q;
				push_hi = place_q;
			end
		end
	end

	assign push_ok = push_en && ((push_hi - push_lo) > CNT_W'(1)) && (sp_q < SP_W'(SK_D));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q  <= '0;
			ovf_q    <= 1'b0;
			sp_q     <= '0;
			strobe_q <= 1'b0;
		end else begin
			if (cmd.clear) begin
				count_q <= '0;
				ovf_q   <= 1'b0;
			end else if (cmd.load) begin
				if (full) begin
					ovf_q <= 1'b1;
				end else begin
					count_q <= count_q + CNT_W'(1);
				end
			end
			if (cmd.pop) begin
				sp_q <= sp_m1;
			end else if (push_ok) begin
				sp_q <= sp_q + SP_W'(1);
			end
			strobe_q <= cmd.read || cmd.done;
		end
	end

	always_ff @(posedge clk) begin
		if (push_ok) begin
			stk_q[sp_q[SI_W-1:0]] <= {push_lo, push_hi};
		end
		if (cmd.pop) begin
			lo_q <= top_lo;
			hi_q <= top_hi;
		end
		if (cmd.start_part) begin
			pivot_q <= rd_data;
			i_q     <= lo_nx;
			place_q <= lo_q;
		end
		if (cmd.take_lt) begin
			place_q <= pl_nx;
			vi_q    <= rd_data;
		end
		if (cmd.step_i) begin
			i_q <= i_nx;
		end
		if (cmd.save_vp) begin
			vp_q <= rd_data;
		end
		if (cmd.read || cmd.done) begin
			kind_rd_q <= cmd.read;
			err_q     <= cmd.read && read_err;
			rsp_cnt_q <= cnt_ext[10:0];
			rsp_ovf_q <= ovf_q;
		end
	end

	assign strobe            = strobe_q;
	assign rsp.out_value     = (kind_rd_q && !err_q) ? out_ext[31:0] : '0;
	assign rsp.out_count     = rsp_cnt_q;
	assign rsp.index_error   = err_q;
	assign rsp.overflow_seen = rsp_ovf_q;

endmodule

/* sv/qsbe_ctrl.sv */
// Controller: takes command words and sequences the partition/stack walk of a sort.
// Depends on qsbe_pkg.
module qsbe_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [1:0]        opcode,
	input  qsbe_pkg::dp_sts_t sts,
	output qsbe_pkg::dp_cmd_t cmd,
	output logic              busy
);

	localparam logic [3:0] S_IDLE  = 4'd0;
	localparam logic [3:0] S_START = 4'd1;
	localparam logic [3:0] S_POP   = 4'd2;
	localparam logic [3:0] S_PIV   = 4'd3;
	localparam logic [3:0] S_CMP   = 4'd4;
	localparam logic [3:0] S_SWA   = 4'd5;
	localparam logic [3:0] S_SWB   = 4'd6;
	localparam logic [3:0] S_FIN1  = 4'd7;
	localparam logic [3:0] S_FIN2  = 4'd8;
	localparam logic [3:0] S_FIN3  = 4'd9;
	localparam logic [3:0] S_PUSHA = 4'd10;
	localparam logic [3:0] S_PUSHB = 4'd11;
	localparam logic [3:0] S_DONE  = 4'd12;

	logic [3:0] state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign busy = (state_q != S_IDLE);

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			S_IDLE: begin
				if (start) begin
					unique case (opcode)
						qsbe_pkg::OP_LOAD: begin
							cmd.load   = 1'b1;
							cmd.wr_en  = 1'b1;
							cmd.wr_sel = qsbe_pkg::WR_LOAD;
						end
						qsbe_pkg::OP_SORT: state_d = S_START;
						qsbe_pkg::OP_READ: begin
							cmd.read   = 1'b1;
							cmd.rd_en  = 1'b1;
							cmd.rd_sel = qsbe_pkg::RA_IDX;
						end
						qsbe_pkg::OP_CLEAR: cmd.clear = 1'b1;
						default: state_d = S_IDLE;
					endcase
				end
			end
			S_START: begin
				if (sts.few) begin
					state_d = S_DONE;
				end else begin
					cmd.push_init = 1'b1;
					state_d = S_POP;
				end
			end
			S_POP: begin
				if (sts.stk_empty) begin
					state_d = S_DONE;
				end else begin
					cmd.pop    = 1'b1;
					cmd.rd_en  = 1'b1;
					cmd.rd_sel = qsbe_pkg::RA_TOP;
					state_d = S_PIV;
				end
			end
			S_PIV: begin
				cmd.start_part = 1'b1;
				cmd.rd_en      = 1'b1;
				cmd.rd_sel     = qsbe_pkg::RA_LO1;
				state_d = S_CMP;
			end
			S_CMP: begin
				if (sts.lt) begin
					cmd.take_lt = 1'b1;
					cmd.rd_en   = 1'b1;
					cmd.rd_sel  = qsbe_pkg::RA_PL1;
					state_d = S_SWA;
				end else if (sts.scan_end) begin
					state_d = S_FIN1;
				end else begin
					cmd.step_i = 1'b1;
					cmd.rd_en  = 1'b1;
					cmd.rd_sel = qsbe_pkg::RA_I1;
					state_d = S_CMP;
				end
			end
			S_SWA: begin
				cmd.wr_en   = 1'b1;
				cmd.wr_sel  = qsbe_pkg::WR_SWA;
				cmd.save_vp = 1'b1;
				state_d = S_SWB;
			end
			S_SWB: begin
				cmd.wr_en  = 1'b1;
				cmd.wr_sel = qsbe_pkg::WR_SWB;
				if (sts.scan_end) begin
					state_d = S_FIN1;
				end else begin
					cmd.step_i = 1'b1;
					cmd.rd_en  = 1'b1;
					cmd.rd_sel = qsbe_pkg::RA_I1;
					state_d = S_CMP;
				end
			end
			S_FIN1: begin
				cmd.rd_en  = 1'b1;
				cmd.rd_sel = qsbe_pkg::RA_PL;
				state_d = S_FIN2;
			end
			S_FIN2: begin
				cmd.wr_en  = 1'b1;
				cmd.wr_sel = qsbe_pkg::WR_FIN2;
				state_d = S_FIN3;
			end
			S_FIN3: begin
				cmd.wr_en  = 1'b1;
				cmd.wr_sel = qsbe_pkg::WR_FIN3;
				state_d = S_PUSHA;
			end
			S_PUSHA: begin
				cmd.push_a = 1'b1;
				state_d = S_PUSHB;
			end
			S_PUSHB: begin
				cmd.push_b = 1'b1;
				state_d = S_POP;
			end
			S_DONE: begin
				cmd.done = 1'b1;
				state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

endmodule

/* sv/quicksort_buffer_engine.sv */
// Quicksort buffer engine, top level: controller plus datapath.
// Load, clear and read words are taken every cycle while not busy (no sort running);
// a read result strobes the next cycle. Sort: busy while each range popped from the
// stack is partitioned, an element below the pivot costing a swap; the result strobes
// as busy drops; presorted input is the worst case. The receiver cannot stall.
// Reset clears count, overflow flag, stack and controller; buffer contents are undefined.
module quicksort_buffer_engine #(
	parameter int DEPTH      = qsbe_pkg::DEPTH_DEF,
	parameter int DATA_WIDTH = qsbe_pkg::DATA_WIDTH_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	output logic           busy,
	input  qsbe_pkg::req_t request,
	output logic           strobe,
	output qsbe_pkg::rsp_t result
);

	qsbe_pkg::dp_cmd_t cmd;
	qsbe_pkg::dp_sts_t sts;

	qsbe_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.opcode (request.opcode),
		.sts    (sts),
		.cmd    (cmd),
		.busy   (busy)
	);

	qsbe_dp #(
		.DEPTH      (DEPTH),
		.DATA_WIDTH (DATA_WIDTH)
	) u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (request),
		.cmd    (cmd),
		.sts    (sts),
		.strobe (strobe),
		.rsp    (result)
	);

endmodule

/* tb/sv/testbench.sv */
`timescale 1ns / 1ps
// Self-checking testbench for quicksort_buffer_engine: directed table, full-buffer
// overflow phase, random clear/load/sort/read runs checked against a shadow model.
// Depends on qsbe_pkg and the engine RTL.
module testbench;
	import qsbe_pkg::*;

	localparam int BUF_DEPTH   = DEPTH_DEF;
	localparam int RAND_ITEMS  = 620;
	localparam int QUIET_TAIL  = 300;
	localparam int CYCLE_LIMIT = 20_000_000;
	localparam int N_DIR       = 25;

	typedef struct packed {
		req_t w;
		bit   has_fixed;
		rsp_t fixed;
	} dir_row_t;

	localparam rsp_t NO_RSP = '0;

	localparam dir_row_t DIR_TAB [N_DIR] = '{
		'{req_t'{OP_READ,  32'h0000_0000, 10'd0},   1'b1, rsp_t'{32'h0000_0000, 11'd0, 1'b1, 1'b0}},
		'{req_t'{OP_SORT,  32'h0000_0000, 10'd0},   1'b1, rsp_t'{32'h0000_0000, 11'd0, 1'b0, 1'b0}},
		'{req_t'{OP_LOAD,  32'h7fff_ffff, 10'd0},   1'b0, NO_RSP},
		'{req_t'{OP_SORT,  32'h0000_0000, 10'd0},   1'b1, rsp_t'{32'h0000_0000, 11'd1, 1'b0, 1'b0}},
		'{req_t'{OP_READ,  32'h0000_0000, 10'd0},   1'b1, rsp_t'{32'h7fff_ffff, 11'd1, 1'b0, 1'b0}},
		'{req_t'{OP_LOAD,  32'h8000_0000, 10'h3ff}, 1'b0, NO_RSP},
		'{req_t'{OP_LOAD,  32'h0000_0000, 10'd0},   1'b0, NO_RSP},
		'{req_t'{OP_LOAD,  32'hffff_ffff, 10'd0},   1'b0, NO_RSP},
		'{req_t'{OP_LOAD,  32'h0000_0001, 10'd0},   1'b0, NO_RSP},
		'{req_t'{OP_LOAD,  32'h7fff_ffff, 10'd0},   1'b0, NO_RSP},
		'{req_t'{OP_LOAD,  32'h8000_0000, 10'd0},   1'b0, NO_RSP},
		'{req_t'{OP_READ,  32'hffff_ffff, 10'h3ff}, 1'b1, rsp_t'{32'h0000_0000, 11'd7, 1'b1, 1'b0}},
		'{req_t'{OP_READ,  32'h0000_0000, 10'd7},   1'b1, rsp_t'{32'h0000_0000, 11'd7, 1'b1, 1'b0}},
		'{req_t'{OP_READ,  32'h0000_0000, 10'd1},   1'b0, NO_RSP},
		'{req_t'{OP_SORT,  32'h0000_0000, 10'd0},   1'b1, rsp_t'{32'h0000_0000, 11'd7, 1'b0, 1'b0}},
		'{req_t'{OP_READ,  32'h0000_0000, 10'd0},   1'b1, rsp_t'{32'h8000_0000, 11'd7, 1'b0, 1'b0}},
		'{req_t'{OP_READ,  32'h0000_0000, 10'd6},   1'b1, rsp_t'{32'h7fff_ffff, 11'd7, 1'b0, 1'b0}},
		'{req_t'{OP_READ,  32'h0000_0000, 10'd3},   1'b0, NO_RSP},
		'{req_t'{OP_READ,  32'h0000_0000, 10'd2},   1'b0, NO_RSP},
		'{req_t'{OP_CLEAR, 32'h0000_0000, 10'd0},   1'b0, NO_RSP},
		'{req_t'{OP_READ,  32'h0000_0000, 10'd0},   1'b1, rsp_t'{32'h0000_0000, 11'd0, 1'b1, 1'b0}},
		'{req_t'{OP_SORT,  32'h0000_0000, 10'd0},   1'b1, rsp_t'{32'h0000_0000, 11'd0, 1'b0, 1'b0}},
		'{req_t'{OP_LOAD,  32'h5555_5555, 10'h2aa}, 1'b0, NO_RSP},
		'{req_t'{OP_READ,  32'haaaa_aaaa, 10'd0},   1'b0, NO_RSP},
		'{req_t'{OP_CLEAR, 32'h0000_0000, 10'd0},   1'b0, NO_RSP}
	};

	logic clk;
	logic arst_n  = 1'b0;
	logic start   = 1'b0;
	req_t request = '0;
	logic busy;
	logic strobe;
	rsp_t result;

	quicksort_buffer_engine dut (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.request(request),
		.strobe (strobe),
		.result (result)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// shadow copy of the engine state
	logic signed [31:0] shadow_buf [BUF_DEPTH];
	int                 shadow_count = 0;
	bit                 shadow_ovf   = 1'b0;

	rsp_t reply_q [$];
	int   errors  = 0;
	int   sent    = 0;
	int   cycles  = 0;
	bit   gaps_on = 1'b1;

	// quicksort, first element of each range as pivot
	function automatic void sort_shadow();
		int unsigned        lo_stk [$];
		int unsigned        hi_stk [$];
		int unsigned        lo;
		int unsigned        hi;
		int unsigned        place;
		logic signed [31:0] t;
		if (shadow_count > 1) begin
			lo_stk.push_back(0);
			hi_stk.push_back(shadow_count);
		end
		while (lo_stk.size() != 0) begin
			lo    = lo_stk.pop_back();
			hi    = hi_stk.pop_back();
			place = lo;
			for (int unsigned i = lo + 1; i < hi; i++) begin
				if (shadow_buf[i] < shadow_buf[lo]) begin
					place++;
					t                 = shadow_buf[place];
					shadow_buf[place] = shadow_buf[i];
					shadow_buf[i]     = t;
				end
			end
			t                 = shadow_buf[lo];
			shadow_buf[lo]    = shadow_buf[place];
			shadow_buf[place] = t;
			if (place - lo > 1) begin
				lo_stk.push_back(lo);
				hi_stk.push_back(place);
			end
			if (hi - place > 2) begin
				lo_stk.push_back(place + 1);
				hi_stk.push_back(hi);
			end
		end
	endfunction

	function automatic bit engine_step(input req_t w, output rsp_t r);
		r = '0;
		case (w.opcode)
		OP_LOAD: begin
			if (shadow_count < BUF_DEPTH) begin
				shadow_buf[shadow_count] = w.data_value;
				shadow_count++;
			end else begin
				shadow_ovf = 1'b1;
			end
			return 1'b0;
		end
		OP_CLEAR: begin
			shadow_count = 0;
			shadow_ovf   = 1'b0;
			return 1'b0;
		end
		OP_SORT: begin
			sort_shadow();
		end
		OP_READ: begin
			if (w.read_index < shadow_count)
				r.out_value = shadow_buf[w.read_index];
			else
				r.index_error = 1'b1;
		end
		default: ;
		endcase
		r.out_count     = 11'(shadow_count);
		r.overflow_seen = shadow_ovf;
		return 1'b1;
	endfunction

	function automatic logic signed [31:0] pick_value();
		case ($urandom_range(0, 7))
		0:       return 32'h8000_0000;
		1:       return 32'h7fff_ffff;
		2, 3:    return 32'($signed($urandom_range(0, 8)) - 4);
		default: return $urandom;
		endcase
	endfunction

	task automatic issue(input req_t w, input bit has_fixed, input rsp_t fixed);
		rsp_t r;
		if (gaps_on && $urandom_range(0, 3) == 0) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 11)) @(posedge clk);
		end
		request <= w;
		start   <= 1'b1;
		@(posedge clk);
		while (busy) @(posedge clk);
		if (engine_step(w, r))
			reply_q.push_back(has_fixed ? fixed : r);
		sent++;
	endtask

	task automatic drain();
		start <= 1'b0;
		do @(posedge clk); while (reply_q.size() != 0);
	endtask

	always @(posedge clk) begin : check_results
		rsp_t want;
		if (arst_n && strobe) begin
			if (reply_q.size() == 0) begin
				$error("unexpected result word: out_value %0d out_count %0d",
					result.out_value, result.out_count);
				errors++;
			end else begin
				want = reply_q.pop_front();
				if (result.out_value !== want.out_value) begin
					$error("out_value: expected %0d, got %0d", want.out_value, result.out_value);
					errors++;
				end
				if (result.out_count !== want.out_count) begin
					$error("out_count: expected %0d, got %0d", want.out_count, result.out_count);
					errors++;
				end
				if (result.index_error !== want.index_error) begin
					$error("index_error: expected %0b, got %0b",
						want.index_error, result.index_error);
					errors++;
				end
				if (result.overflow_seen !== want.overflow_seen) begin
					$error("overflow_seen: expected %0b, got %0b",
						want.overflow_seen, result.overflow_seen);
					errors++;
				end
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles == CYCLE_LIMIT) begin
			$display("Simulation FAILED");
			$finish;
		end
	end

	initial begin : stimulus
		int      rand_end;
		int      n;
		logic [9:0] idx;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int k = 0; k < N_DIR; k++)
			issue(DIR_TAB[k].w, DIR_TAB[k].has_fixed, DIR_TAB[k].fixed);
		drain();

		// fill past capacity, sort the full buffer once, read both ends
		issue(req_t'{OP_CLEAR, pick_value(), 10'($urandom)}, 1'b0, NO_RSP);
		repeat (BUF_DEPTH + 4)
			issue(req_t'{OP_LOAD, pick_value(), 10'($urandom)}, 1'b0, NO_RSP);
		issue(req_t'{OP_READ, pick_value(), 10'h3ff}, 1'b0, NO_RSP);
		issue(req_t'{OP_SORT, pick_value(), 10'($urandom)}, 1'b0, NO_RSP);
		issue(req_t'{OP_READ, pick_value(), 10'd0}, 1'b0, NO_RSP);
		issue(req_t'{OP_READ, pick_value(), 10'h3ff}, 1'b0, NO_RSP);
		repeat (6)
			issue(req_t'{OP_READ, pick_value(), 10'($urandom)}, 1'b0, NO_RSP);
		issue(req_t'{OP_CLEAR, pick_value(), 10'($urandom)}, 1'b0, NO_RSP);
		issue(req_t'{OP_READ, pick_value(), 10'd0}, 1'b0, NO_RSP);
		drain();

		rand_end = sent + RAND_ITEMS;
		while (sent < rand_end) begin
			gaps_on = (sent < rand_end - QUIET_TAIL) && ($urandom_range(0, 3) != 0);
			if ($urandom_range(0, 9) == 0)
				drain();
			if ($urandom_range(0, 7) == 0 && shadow_count < 200) begin
				// noise: any opcode, any fields
				repeat ($urandom_range(1, 6))
					issue(req_t'{2'($urandom), pick_value(), 10'($urandom)}, 1'b0, NO_RSP);
			end else begin
				if (shadow_count > 200 || $urandom_range(0, 3) != 0)
					issue(req_t'{OP_CLEAR, pick_value(), 10'($urandom)}, 1'b0, NO_RSP);
				n = ($urandom_range(0, 9) == 0) ? $urandom_range(25, 180)
				                                : $urandom_range(0, 24);
				repeat (n)
					issue(req_t'{OP_LOAD, pick_value(), 10'($urandom)}, 1'b0, NO_RSP);
				if ($urandom_range(0, 7) != 0) begin
					issue(req_t'{OP_SORT, pick_value(), 10'($urandom)}, 1'b0, NO_RSP);
					if ($urandom_range(0, 9) == 0)
						issue(req_t'{OP_SORT, pick_value(), 10'($urandom)}, 1'b0, NO_RSP);
				end
				repeat ($urandom_range(1, 12)) begin
					if (shadow_count > 0 && $urandom_range(0, 4) != 0)
						idx = 10'($urandom_range(0, shadow_count - 1));
					else
						idx = 10'($urandom);
					issue(req_t'{OP_READ, pick_value(), idx}, 1'b0, NO_RSP);
				end
			end
		end

		drain();
		repeat (16) @(posedge clk);
		if (errors == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule
